// ===== design/assert_macros.svh =====
// assertion helpers for the rational arithmetic unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RAU_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define RAU_ASSERT_NR(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define RAU_ASSERT(lbl, clk, rst_n, prop)
`define RAU_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// ===== design/rau_pkg.sv =====
`default_nettype none
package rau_pkg;
	localparam int unsigned FW = 32;
	localparam logic [2:0] KIND_ADD = 3'd0;
	localparam logic [2:0] KIND_SUB = 3'd1;
	localparam logic [2:0] KIND_MUL = 3'd2;
	localparam logic [2:0] KIND_DIV = 3'd3;
	localparam logic [2:0] KIND_POW = 3'd4;

	typedef struct packed {
		logic [2:0] kind;
		logic signed [FW-1:0] a_num;
		logic signed [FW-1:0] a_den;
		logic signed [FW-1:0] b_num;
		logic signed [FW-1:0] b_den;
	} req_t;

	typedef struct packed {
		logic signed [FW-1:0] res_num;
		logic signed [FW-1:0] res_den;
		logic error;
	} rsp_t;

	typedef enum logic [1:0] {
		OP_RED, // cross products, then reduce
		OP_POW,
		OP_ERR
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_X1, ST_X2, ST_X3, ST_GCD_START, ST_GCD_WAIT,
		ST_Q1, ST_Q1_WAIT, ST_Q2_WAIT, ST_POW_N, ST_POW_D, ST_DONE
	} bst_t;
endpackage
`default_nettype wire

// ===== design/rau_divider.sv =====
`default_nettype none
// unsigned restoring divider, one quotient bit a cycle
module rau_divider import rau_pkg::*; #(
	parameter int unsigned W = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [W-1:0] dividend,
	input wire logic [W-1:0] divisor,
	output logic busy,
	output logic done,
	output logic [W-1:0] quot,
	output logic [W-1:0] rem
);
	localparam int unsigned CW = $clog2(W + 1);
	logic [CW-1:0] cnt_q;
	logic [W-1:0] dvs_q;
	logic [W:0] trial;

	assign trial = {rem[W-1:0], quot[W-1]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy <= 1'b1;
				cnt_q <= CW'(W);
			end else if (busy) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot <= dividend;
			rem <= '0;
			dvs_q <= divisor;
		end else if (busy) begin
			if (!trial[W]) begin
				rem <= trial[W-1:0];
				quot <= {quot[W-2:0], 1'b1};
			end else begin
				rem <= {rem[W-2:0], quot[W-1]};
				quot <= {quot[W-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// ===== design/rau_front.sv =====
`default_nettype none
// accepts requests, classifies them, and keeps a two-entry queue for the back end
module rau_front import rau_pkg::*; #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned MAX_EXP = 31
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire req_t in_req,
	output logic in_stall,
	output logic q_valid,
	output req_t q_req,
	output op_t q_op,
	input wire logic q_take
);
	req_t req_q [2];
	op_t op_q [2];
	logic [1:0] cnt_q;
	logic wr_q, rd_q;
	logic push, pop;
	op_t cls;
	logic [WIDTH-1:0] bnw, emag;

	// exponent seen at the working width
	assign bnw = WIDTH'($signed(in_req.b_num));
	assign emag = bnw[WIDTH-1] ? -bnw : bnw;

	always_comb begin
		case (in_req.kind)
			KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: cls = OP_RED;
			KIND_POW: cls = (emag > WIDTH'(MAX_EXP)) ? OP_ERR : OP_POW;
			default: cls = OP_ERR;
		endcase
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && q_take;
	assign q_req = req_q[rd_q];
	assign q_op = op_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q <= 1'b0;
			rd_q <= 1'b0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			req_q[wr_q] <= in_req;
			op_q[wr_q] <= cls;
		end
	end

	`include "assert_macros.svh"
	`RAU_ASSERT(a_no_overflow, clk, arst_n, cnt_q <= 2'd2)
	`RAU_ASSERT(a_push_full, clk, arst_n, (cnt_q == 2'd2) |-> !push)
	`RAU_ASSERT(a_pop_empty, clk, arst_n, (cnt_q == 2'd0) |-> !pop)
endmodule
`default_nettype wire

// ===== design/rau_back.sv =====
`default_nettype none
// executes one request at a time: cross products, euclid on the shared divider, power loop
module rau_back import rau_pkg::*; #(
	parameter int unsigned WIDTH = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	input wire req_t q_req,
	input wire op_t q_op,
	output logic q_take,
	output logic out_valid,
	output rsp_t out_rsp,
	input wire logic out_stall
);
	localparam int unsigned EW = 6;
	bst_t st_q, st_d;
	logic [2:0] kind_q;
	logic [WIDTH-1:0] an_q, ad_q, bn_q, bd_q;
	logic [WIDTH-1:0] p_q, num_q, den_q, x_q, y_q;
	logic [EW-1:0] e_q;
	logic err_q;
	logic [WIDTH-1:0] ma, mb, prod;
	logic dv_start, dv_busy, dv_done;
	logic [WIDTH-1:0] dv_n, dv_d, dv_quo, dv_rem;
	logic neg_n, neg_d;
	logic [WIDTH-1:0] srem, sq;
	logic [WIDTH-1:0] q_bn;

	function automatic logic [WIDTH-1:0] ext(input logic [FW-1:0] v);
		return WIDTH'($signed(v));
	endfunction

	function automatic logic [WIDTH-1:0] mag(input logic [WIDTH-1:0] v);
		return v[WIDTH-1] ? -v : v;
	endfunction

	assign q_bn = ext(q_req.b_num);

	// one shared multiplier, low bits only
	assign prod = ma * mb;
	always_comb begin
		ma = an_q;
		mb = bd_q;
		unique case (st_q)
			ST_X1: begin ma = an_q; mb = (kind_q == KIND_MUL) ? bn_q : bd_q; end
			ST_X2: begin ma = ad_q; mb = (kind_q == KIND_DIV) ? bn_q : bd_q; end
			ST_X3: begin ma = ad_q; mb = bn_q; end
			ST_POW_N: begin ma = num_q; mb = an_q; end
			ST_POW_D: begin ma = den_q; mb = ad_q; end
			default: ;
		endcase
	end

	rau_divider #(.W(WIDTH)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start),
		.dividend(dv_n), .divisor(dv_d),
		.busy(dv_busy), .done(dv_done), .quot(dv_quo), .rem(dv_rem)
	);

	assign srem = neg_n ? -dv_rem : dv_rem;
	assign sq = (neg_n != neg_d) ? -dv_quo : dv_quo;

	always_comb begin
		st_d = st_q;
		q_take = 1'b0;
		dv_start = 1'b0;
		dv_n = mag(x_q);
		dv_d = mag(y_q);
		neg_n = x_q[WIDTH-1];
		neg_d = y_q[WIDTH-1];
		unique case (st_q)
			ST_IDLE: if (q_valid) begin
				q_take = 1'b1;
				unique case (q_op)
					OP_RED: st_d = ST_X1;
					OP_POW: st_d = ST_POW_N;
					default: st_d = ST_DONE;
				endcase
			end
			ST_X1: st_d = ST_X2;
			ST_X2: st_d = (kind_q == KIND_ADD || kind_q == KIND_SUB) ? ST_X3 : ST_GCD_START;
			ST_X3: st_d = ST_GCD_START;
			ST_GCD_START: begin
				if (y_q == '0) begin
					st_d = (x_q == '0) ? ST_DONE : ST_Q1;
				end else begin
					dv_start = 1'b1;
					st_d = ST_GCD_WAIT;
				end
			end
			ST_GCD_WAIT: if (dv_done) st_d = ST_GCD_START;
			ST_Q1: begin
				dv_n = mag(num_q);
				dv_d = mag(x_q);
				dv_start = 1'b1;
				st_d = ST_Q1_WAIT;
			end
			ST_Q1_WAIT: begin
				neg_n = num_q[WIDTH-1];
				neg_d = x_q[WIDTH-1];
				dv_n = mag(den_q);
				dv_d = mag(x_q);
				if (dv_done) begin
					dv_start = 1'b1;
					st_d = ST_Q2_WAIT;
				end
			end
			ST_Q2_WAIT: begin
				neg_n = den_q[WIDTH-1];
				neg_d = x_q[WIDTH-1];
				if (dv_done) st_d = ST_DONE;
			end
			ST_POW_N: st_d = (e_q == '0) ? ST_DONE : ST_POW_D;
			ST_POW_D: st_d = ST_POW_N;
			ST_DONE: if (!out_stall) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else st_q <= st_d;
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				kind_q <= q_req.kind;
				err_q <= (q_op == OP_ERR);
				bn_q <= q_bn;
				bd_q <= ext(q_req.b_den);
				num_q <= WIDTH'(1);
				den_q <= WIDTH'(1);
				e_q <= EW'(mag(q_bn));
				// negative exponent swaps the parts of a
				if (q_op == OP_POW && q_bn[WIDTH-1]) begin
					an_q <= ext(q_req.a_den);
					ad_q <= ext(q_req.a_num);
				end else begin
					an_q <= ext(q_req.a_num);
					ad_q <= ext(q_req.a_den);
				end
			end
			ST_X1: p_q <= prod;
			ST_X2: begin
				if (kind_q == KIND_ADD || kind_q == KIND_SUB) begin
					den_q <= prod;
				end else begin
					num_q <= p_q;
					den_q <= prod;
					x_q <= p_q;
					y_q <= prod;
				end
			end
			ST_X3: begin
				num_q <= (kind_q == KIND_ADD) ? p_q + prod : p_q - prod;
				x_q <= (kind_q == KIND_ADD) ? p_q + prod : p_q - prod;
				y_q <= den_q;
			end
			ST_GCD_START: if (y_q == '0 && x_q == '0) err_q <= 1'b1;
			ST_GCD_WAIT: if (dv_done) begin
				x_q <= y_q;
				y_q <= srem;
			end
			ST_Q1_WAIT: if (dv_done) num_q <= sq;
			ST_Q2_WAIT: if (dv_done) den_q <= sq;
			ST_POW_N: if (e_q != '0) num_q <= prod;
			ST_POW_D: begin
				den_q <= prod;
				e_q <= e_q - 1'b1;
			end
			default: ;
		endcase
	end

	assign out_valid = (st_q == ST_DONE);
	assign out_rsp.res_num = err_q ? '0 : FW'($signed(num_q));
	assign out_rsp.res_den = err_q ? '0 : FW'($signed(den_q));
	assign out_rsp.error = err_q;

	`include "assert_macros.svh"
	`RAU_ASSERT(a_take_idle, clk, arst_n, q_take |-> (st_q == ST_IDLE))
	`RAU_ASSERT(a_div_free, clk, arst_n, dv_start |-> !dv_busy)
	`RAU_ASSERT(a_hold, clk, arst_n, (out_valid && out_stall) |=> out_valid && $stable(out_rsp))
endmodule
`default_nettype wire

// ===== design/rational_arith_unit_top.sv =====
`default_nettype none
// Fraction arithmetic unit: add, subtract, multiply, divide (reduced by a truncating-remainder
// euclid gcd) and integer power (not reduced). One request is worked at a time in the back
// end; a two-entry queue in the front end takes up to two more. Power multiplies both parts
// once per exponent step (exponent magnitude at most MAX_EXP); the other kinds run the
// gcd steps on the shared bit-serial divider and then two more divisions for the
// reduction. Errors give 0/0.
module rational_arith_unit_top import rau_pkg::*; #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned MAX_EXP = 31
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire req_t in_req,
	output logic out_valid,
	input wire logic out_stall,
	output rsp_t out_rsp
);
	logic q_valid, q_take;
	req_t q_req;
	op_t q_op;

	rau_front #(.WIDTH(WIDTH), .MAX_EXP(MAX_EXP)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_req(in_req),
		.in_stall(in_stall), .q_valid(q_valid), .q_req(q_req), .q_op(q_op),
		.q_take(q_take)
	);

	rau_back #(.WIDTH(WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_req(q_req), .q_op(q_op),
		.q_take(q_take), .out_valid(out_valid), .out_rsp(out_rsp), .out_stall(out_stall)
	);
endmodule
`default_nettype wire

// ===== verif/rau_checker.sv =====
`default_nettype none
module rau_checker import rau_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire req_t in_req,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire rsp_t out_rsp,
	output int fail_count,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_EXP = 31;

	rsp_t expected_q[$];

	function automatic logic [31:0] mag(logic [31:0] v);
		return v[31] ? -v : v;
	endfunction

	function automatic logic [31:0] srem(logic [31:0] n, logic [31:0] d);
		logic [31:0] r;
		r = mag(n) % mag(d);
		return n[31] ? -r : r;
	endfunction

	function automatic logic [31:0] squot(logic [31:0] n, logic [31:0] d);
		logic [31:0] q;
		q = mag(n) / mag(d);
		return (n[31] != d[31]) ? -q : q;
	endfunction

	function automatic rsp_t fraction_result(req_t r);
		rsp_t o;
		logic [31:0] an, ad, bn, bd, num, den, x, y, t, e;
		int k;
		logic bad;
		an = r.a_num; ad = r.a_den; bn = r.b_num; bd = r.b_den;
		num = '0; den = '0; bad = 1'b0;
		if (r.kind == KIND_POW) begin
			e = mag(bn);
			if (bn[31]) begin
				t = an; an = ad; ad = t;
			end
			if (e > MAX_EXP) begin
				bad = 1'b1;
			end else begin
				num = 1; den = 1;
				for (k = 0; k < e; k++) begin
					num = num * an;
					den = den * ad;
				end
			end
		end else if (r.kind inside {KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV}) begin
			case (r.kind)
				KIND_ADD: begin num = an * bd + ad * bn; den = ad * bd; end
				KIND_SUB: begin num = an * bd - ad * bn; den = ad * bd; end
				KIND_MUL: begin num = an * bn; den = ad * bd; end
				default: begin num = an * bd; den = ad * bn; end
			endcase
			x = num; y = den;
			while (y != 0) begin
				t = srem(x, y); x = y; y = t;
			end
			if (x == 0) begin
				bad = 1'b1;
			end else begin
				num = squot(num, x);
				den = squot(den, x);
			end
		end else begin
			bad = 1'b1;
		end
		if (bad) begin
			num = '0; den = '0;
		end
		o.res_num = num; o.res_den = den; o.error = bad;
		return o;
	endfunction

	assign pending = expected_q.size();

	initial fail_count = 0;

	always @(posedge clk) begin
		rsp_t exp_rsp;
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_q.push_back(fraction_result(in_req));
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					fail_count <= fail_count + 1;
					$display("%0t unexpected result: actual %0d/%0d err %0b", $time,
						out_rsp.res_num, out_rsp.res_den, out_rsp.error);
				end else begin
					exp_rsp = expected_q.pop_front();
					if (exp_rsp !== out_rsp) begin
						fail_count <= fail_count + 1;
						$display("%0t mismatch: expected %0d/%0d err %0b, actual %0d/%0d err %0b",
							$time, exp_rsp.res_num, exp_rsp.res_den, exp_rsp.error,
							out_rsp.res_num, out_rsp.res_den, out_rsp.error);
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== verif/tb_rational_arith_unit_top.sv =====
`default_nettype none
module tb_rational_arith_unit_top import rau_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM = 730;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk, arst_n, in_valid, in_stall, out_valid, out_stall;
	req_t in_req;
	rsp_t out_rsp;
	int fail_count, pending, idle_cycles;
	logic sending_done, calm, hold_off;

	rational_arith_unit_top dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_req(in_req), .out_valid(out_valid), .out_stall(out_stall), .out_rsp(out_rsp)
	);

	rau_checker chk (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_req(in_req), .out_valid(out_valid), .out_stall(out_stall), .out_rsp(out_rsp),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 0;
			4, 5, 6: return $urandom_range(0, 40) - 20;
			7: return $urandom_range(0, 2000) - 1000;
			default: return $urandom;
		endcase
	endfunction

	function automatic req_t random_request();
		req_t r;
		r.kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
			: 3'($urandom_range(KIND_ADD, KIND_POW));
		r.a_num = pick_value(); r.a_den = pick_value();
		r.b_num = pick_value(); r.b_den = pick_value();
		if (r.kind == KIND_POW && $urandom_range(0, 9) < 8)
			r.b_num = $urandom_range(0, 70) - 35;
		return r;
	endfunction

	task automatic send_request(req_t r);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 17) @(negedge clk);
		in_valid <= 1'b1;
		in_req <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	function automatic req_t make_req(logic [2:0] k, logic [31:0] an, logic [31:0] ad,
		logic [31:0] bn, logic [31:0] bd);
		req_t r;
		r.kind = k; r.a_num = an; r.a_den = ad; r.b_num = bn; r.b_den = bd;
		return r;
	endfunction

	// receiver: random stalls, one long hold-off while requests keep coming
	initial begin
		int hold;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
				for (hold = 0; hold < 3000; hold++) @(negedge clk);
				hold_off = 1'b0;
			end
			out_stall <= !calm && ($urandom_range(0, 99) < 17);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int i;
		in_valid = 1'b0;
		in_req = '0;
		arst_n = 1'b0;
		calm = 1'b0;
		hold_off = 1'b0;
		sending_done = 1'b0;
		idle_cycles = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_request(make_req(KIND_ADD, 1, 2, 1, 3));
		send_request(make_req(KIND_SUB, 1, 2, 1, 2));
		send_request(make_req(KIND_MUL, -3, 4, 8, -9));
		send_request(make_req(KIND_DIV, 2, 3, 4, 5));
		send_request(make_req(KIND_DIV, 2, 3, 0, 5));
		send_request(make_req(KIND_ADD, 0, 0, 0, 0));
		send_request(make_req(KIND_MUL, 0, 7, 5, 0));
		send_request(make_req(KIND_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1));
		send_request(make_req(KIND_DIV, 32'h8000_0000, 1, -1, 1));
		send_request(make_req(KIND_MUL, 32'h8000_0000, 32'h8000_0000, -1, -1));
		send_request(make_req(KIND_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 3));
		send_request(make_req(KIND_POW, 2, 3, 0, 9));
		send_request(make_req(KIND_POW, 2, 3, 5, 9));
		send_request(make_req(KIND_POW, 2, 3, -4, 9));
		send_request(make_req(KIND_POW, 3, 7, 31, 0));
		send_request(make_req(KIND_POW, 3, 7, -31, 0));
		send_request(make_req(KIND_POW, 3, 7, 32, 0));
		send_request(make_req(KIND_POW, 3, 7, -32, 0));
		send_request(make_req(KIND_POW, 3, 7, 32'h8000_0000, 0));
		send_request(make_req(KIND_POW, 32'h8000_0000, 32'h7fff_ffff, 2, 32'hffff_ffff));
		send_request(make_req(3'd5, 1, 1, 1, 1));
		send_request(make_req(3'd6, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
		send_request(make_req(3'd7, 0, 0, 0, 0));

		for (i = 0; i < N_RANDOM; i++) begin
			if (i == 100) hold_off = 1'b1;
			calm = (i >= 300 && i < 400);
			send_request(random_request());
		end
		calm = 1'b0;
		sending_done = 1'b1;

		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire
